### hw/rtl/sdt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared constants, codes and controller/datapath signal groups of the
// subset pair dedup table.
// ----------------------------------------------------------------------------
package sdt_pkg;

   localparam int MAX_NODES_DEF = 64;
   localparam int MAX_PAIRS_DEF = 1024;
   localparam int MAX_SEEN_DEF  = 2048;

   localparam int SET_W    = 64;
   localparam int NODE_W   = 6;
   localparam int EDGE_W   = 16;
   localparam int BUDGET_W = 11;
   localparam int NCOUNT_W = 7;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(1024);
   localparam logic [NCOUNT_W-1:0] NCOUNT_RESET = '0;

   typedef enum logic {
      REG_PAIR_QUOTA = 1'b0,
      REG_NODE_SPAN  = 1'b1
   } reg_idx_type;

   typedef enum logic {
      OP_SINGLE = 1'b0,
      OP_PAIR   = 1'b1
   } op_type;

   typedef enum logic {
      SCAN_PAIR = 1'b0,
      SCAN_SEEN = 1'b1
   } scan_sel_type;

   typedef struct packed {
      logic         load;
      logic         scan_start;
      logic         scan_run;
      scan_sel_type scan_sel;
      logic         pair_decide;
      logic         seen_decide;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_pair;
      logic scan_done;
      logic rsp_busy;
   } status_type;

endpackage
`default_nettype wire

### hw/rtl/sdt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdt_req_if / sdt_rsp_if
// Valid/ready channels that carry request and response words.
// ----------------------------------------------------------------------------
interface sdt_req_if
   import sdt_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              operation;
   logic [NODE_W-1:0] node_id;
   logic [SET_W-1:0]  left_set;
   logic [SET_W-1:0]  right_set;
   logic [EDGE_W-1:0] edge_id;

   modport source (output valid, operation, node_id, left_set, right_set, edge_id,
                   input ready);
   modport sink   (input valid, operation, node_id, left_set, right_set, edge_id,
                   output ready);
endinterface

interface sdt_rsp_if;
   logic valid;
   logic ready;
   logic stop;
   logic pair_added;
   logic set_added;
   logic complete;

   modport source (output valid, stop, pair_added, set_added, complete, input ready);
   modport sink   (input valid, stop, pair_added, set_added, complete, output ready);
endinterface
`default_nettype wire

### hw/rtl/sdt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdt_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module sdt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### hw/rtl/sdt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdt_ctrl
// Sequencer: pair scan and decision, seen scan and decision, response.
// ----------------------------------------------------------------------------
module sdt_ctrl
   import sdt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_P_START, ST_P_SCAN, ST_P_DEC, ST_S_START, ST_S_SCAN, ST_S_DEC, ST_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.scan_sel = SCAN_SEEN;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_P_START;
            end
         end
         ST_P_START: begin
            if (status.is_pair) begin
               cmd.scan_sel   = SCAN_PAIR;
               cmd.scan_start = 1'b1;
               state_in       = ST_P_SCAN;
            end else begin
               state_in = ST_S_START;
            end
         end
         ST_P_SCAN: begin
            cmd.scan_sel = SCAN_PAIR;
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = ST_P_DEC;
            end
         end
         ST_P_DEC: begin
            cmd.pair_decide = 1'b1;
            state_in        = ST_S_START;
         end
         ST_S_START: begin
            cmd.scan_start = 1'b1;
            state_in       = ST_S_SCAN;
         end
         ST_S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = ST_S_DEC;
            end
         end
         ST_S_DEC: begin
            cmd.seen_decide = 1'b1;
            state_in        = ST_RESP;
         end
         ST_RESP: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

### hw/rtl/sdt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdt_dp
// Datapath: operand registers, the pair and seen-set memories, the scan
// counter with its comparators, the counts, the exhausted flag and the
// response register.
// ----------------------------------------------------------------------------
module sdt_dp
   import sdt_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF,
   parameter int MAX_PAIRS = MAX_PAIRS_DEF,
   parameter int MAX_SEEN  = MAX_SEEN_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output status_type               status,
   input  wire logic [BUDGET_W-1:0] pair_quota,
   input  wire logic [NCOUNT_W-1:0] node_span,
   input  wire logic                req_operation,
   input  wire logic [NODE_W-1:0]   req_node_id,
   input  wire logic [SET_W-1:0]    req_left_set,
   input  wire logic [SET_W-1:0]    req_right_set,
   input  wire logic [EDGE_W-1:0]   req_edge_id,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output logic                     rsp_stop,
   output logic                     rsp_pair_added,
   output logic                     rsp_set_added,
   output logic                     rsp_complete
);
   localparam int PT_W   = $clog2(MAX_PAIRS + 1);
   localparam int ST_W   = $clog2(MAX_SEEN + 1);
   localparam int P_AW   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int S_AW   = $clog2(MAX_SEEN);
   localparam int IDX_W  = (PT_W > ST_W) ? PT_W : ST_W;
   localparam int CMP_W  = (PT_W > BUDGET_W) ? PT_W : BUDGET_W;
   localparam int PW     = 2 * SET_W + EDGE_W;
   localparam logic [SET_W-1:0] NODE_MASK = {SET_W{1'b1}} >> (SET_W - MAX_NODES);
   localparam logic [NODE_W:0]  NODE_LIM  = (NODE_W + 1)'(MAX_NODES);

   logic [SET_W-1:0]  left_ff, right_ff, target_ff;
   logic [EDGE_W-1:0] edge_ff;
   logic              op_ff, node_ok_ff;
   logic [PT_W-1:0]   pair_total_ff;
   logic [ST_W-1:0]   seen_total_ff;
   logic              exhausted_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              pend_ff, hit_ff, full_hit_ff;
   logic              stop_ff, padd_ff, sadd_ff;
   logic              rsp_valid_ff, rsp_stop_ff, rsp_padd_ff, rsp_sadd_ff, rsp_cmpl_ff;

   logic [SET_W-1:0]  a_in, b_in, full_mask;
   logic [IDX_W-1:0]  limit;
   logic              issue, match, ins_ok;
   logic [CMP_W-1:0]  budget_x, budget_eff;
   logic              budget_full, seen_full, pair_wr, seen_wr;
   logic [PW-1:0]     pair_rd;
   logic [SET_W-1:0]  seen_rd, pl, pr;

   assign a_in      = req_left_set & NODE_MASK;
   assign b_in      = req_right_set & NODE_MASK;
   assign full_mask = ~({SET_W{1'b1}} << node_span);

   assign budget_x    = CMP_W'(pair_quota);
   assign budget_eff  = (budget_x > CMP_W'(MAX_PAIRS)) ? CMP_W'(MAX_PAIRS) : budget_x;
   assign budget_full = CMP_W'(pair_total_ff) >= budget_eff;
   assign seen_full   = seen_total_ff >= ST_W'(MAX_SEEN);

   assign limit = (cmd.scan_sel == SCAN_PAIR) ? IDX_W'(pair_total_ff)
                                              : IDX_W'(seen_total_ff);
   assign issue = idx_ff < limit;

   assign pl    = pair_rd[SET_W-1:0];
   assign pr    = pair_rd[2*SET_W-1:SET_W];
   assign match = (cmd.scan_sel == SCAN_PAIR)
                ? ((pl == left_ff && pr == right_ff) || (pl == right_ff && pr == left_ff))
                : (seen_rd == target_ff);

   assign ins_ok  = (op_ff == OP_PAIR) ? padd_ff : node_ok_ff;
   assign pair_wr = cmd.pair_decide && !hit_ff && !budget_full;
   assign seen_wr = cmd.seen_decide && ins_ok && !hit_ff && !seen_full;

   sdt_ram #(.WIDTH(PW), .DEPTH(MAX_PAIRS)) u_pair_ram (
      .clock   (clock),
      .wr_en   (pair_wr),
      .wr_addr (pair_total_ff[P_AW-1:0]),
      .wr_data ({edge_ff, right_ff, left_ff}),
      .rd_addr (idx_ff[P_AW-1:0]),
      .rd_data (pair_rd)
   );

   sdt_ram #(.WIDTH(SET_W), .DEPTH(MAX_SEEN)) u_seen_ram (
      .clock   (clock),
      .wr_en   (seen_wr),
      .wr_addr (seen_total_ff[S_AW-1:0]),
      .wr_data (target_ff),
      .rd_addr (idx_ff[S_AW-1:0]),
      .rd_data (seen_rd)
   );

   // Operand registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_operation;
         node_ok_ff <= {1'b0, req_node_id} < NODE_LIM;
         left_ff    <= a_in;
         right_ff   <= b_in;
         edge_ff    <= req_edge_id;
         target_ff  <= (req_operation == OP_PAIR) ? (a_in | b_in)
                                                  : (SET_W'(1) << req_node_id);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_total_ff <= '0;
         seen_total_ff <= '0;
         exhausted_ff  <= 1'b0;
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         full_hit_ff   <= 1'b0;
         stop_ff       <= 1'b0;
         padd_ff       <= 1'b0;
         sadd_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            stop_ff <= 1'b0;
            padd_ff <= 1'b0;
            sadd_ff <= 1'b0;
         end
         if (cmd.scan_start) begin
            idx_ff      <= '0;
            pend_ff     <= 1'b0;
            hit_ff      <= 1'b0;
            full_hit_ff <= 1'b0;
         end else if (cmd.scan_run) begin
            if (issue) begin
               idx_ff <= idx_ff + IDX_W'(1);
            end
            pend_ff <= issue;
            if (pend_ff && match) begin
               hit_ff <= 1'b1;
            end
            if (pend_ff && cmd.scan_sel == SCAN_SEEN && seen_rd == full_mask) begin
               full_hit_ff <= 1'b1;
            end
         end
         if (cmd.pair_decide && !hit_ff) begin
            if (budget_full) begin
               exhausted_ff <= 1'b1;
               stop_ff      <= 1'b1;
            end else begin
               pair_total_ff <= pair_total_ff + PT_W'(1);
               padd_ff       <= 1'b1;
            end
         end
         if (seen_wr) begin
            seen_total_ff <= seen_total_ff + ST_W'(1);
            sadd_ff       <= 1'b1;
            if (target_ff == full_mask) begin
               full_hit_ff <= 1'b1;
            end
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_stop_ff <= stop_ff;
         rsp_padd_ff <= padd_ff;
         rsp_sadd_ff <= sadd_ff;
         rsp_cmpl_ff <= !exhausted_ff && node_span != '0
                        && {1'b0, node_span[NCOUNT_W-1:0]} <= {1'b0, NODE_LIM}
                        && full_hit_ff;
      end
   end

   assign status.is_pair   = (op_ff == OP_PAIR);
   assign status.scan_done = !issue && !pend_ff;
   assign status.rsp_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_stop       = rsp_stop_ff;
   assign rsp_pair_added = rsp_padd_ff;
   assign rsp_set_added  = rsp_sadd_ff;
   assign rsp_complete   = rsp_cmpl_ff;
endmodule
`default_nettype wire

### hw/rtl/subset_pair_dedup_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// subset_pair_dedup_table
// Memo table for join enumeration: deduplicated node-set pairs and seen sets.
// ----------------------------------------------------------------------------
// Each request word is either a single-node event or a pair event, and each
// produces exactly one response word. A pair event first scans the pair
// memory for the unordered pair; a new pair is stored if the budget allows,
// otherwise the sticky exhausted flag is set and stop is reported. Every event
// then scans the seen-set memory once: the scan both tells whether the new set
// is already present and whether the full set of the first node-span nodes
// has been seen, which drives complete. Both memories are searched linearly
// through their single read port, one entry per cycle. One word is worked on
// at a time; the response register lets the next request be accepted while
// the previous response still waits. The pair quota register (address 0) and
// the node span register (address 4) are written through the APB-style port
// and should only be changed while the block is idle.
// ----------------------------------------------------------------------------
module subset_pair_dedup_table
   import sdt_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF,
   parameter int MAX_PAIRS = MAX_PAIRS_DEF,
   parameter int MAX_SEEN  = MAX_SEEN_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   sdt_req_if.sink                req_chan,
   sdt_rsp_if.source              rsp_chan,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);
   logic [BUDGET_W-1:0] pair_quota_ff;
   logic [NCOUNT_W-1:0] node_span_ff;
   reg_idx_type         reg_sel;
   logic                csr_wr;
   cmd_type             cmd;
   status_type          status;

   // Register decode uses the word address bit; the byte offset is ignored.
   assign reg_sel    = reg_idx_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_quota_ff <= BUDGET_RESET;
         node_span_ff  <= NCOUNT_RESET;
      end else if (csr_wr) begin
         case (reg_sel)
            REG_PAIR_QUOTA: pair_quota_ff <= csr_pwdata[BUDGET_W-1:0];
            REG_NODE_SPAN:  node_span_ff  <= csr_pwdata[NCOUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_PAIR_QUOTA: csr_prdata = CSR_DW'(pair_quota_ff);
         REG_NODE_SPAN:  csr_prdata = CSR_DW'(node_span_ff);
         default:        csr_prdata = '0;
      endcase
   end

   sdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sdt_dp #(
      .MAX_NODES (MAX_NODES),
      .MAX_PAIRS (MAX_PAIRS),
      .MAX_SEEN  (MAX_SEEN)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .pair_quota     (pair_quota_ff),
      .node_span      (node_span_ff),
      .req_operation  (req_chan.operation),
      .req_node_id    (req_chan.node_id),
      .req_left_set   (req_chan.left_set),
      .req_right_set  (req_chan.right_set),
      .req_edge_id    (req_chan.edge_id),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_stop       (rsp_chan.stop),
      .rsp_pair_added (rsp_chan.pair_added),
      .rsp_set_added  (rsp_chan.set_added),
      .rsp_complete   (rsp_chan.complete)
   );
endmodule
`default_nettype wire

### test/subset_pair_dedup_table_test.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// subset_pair_dedup_table_test
// Self-checking testbench for the subset pair dedup table.
// ----------------------------------------------------------------------------
// Request words go in and response words come out over valid/ready channels.
// A scoreboard keeps its own copy of the seen-set store, the pair store and
// the registers, predicts one response per accepted request, and compares
// every response field by field. A short directed part covers the corner
// cases. It is followed by random pair and single-node traffic drawn from a
// small pool of sets, so that duplicates are common. Both sides idle at
// random, and the register settings change between phases while the block
// is idle.
// ----------------------------------------------------------------------------
module subset_pair_dedup_table_test;
   import sdt_pkg::*;

   typedef struct packed {
      logic stop;
      logic pair_added;
      logic set_added;
      logic complete;
   } outcome_type;

   // The scoreboard holds the predicted contents of both stores and a queue of
   // the outcomes that are still owed by the block.
   class dedup_scoreboard;
      logic [SET_W-1:0]  seen_sets[$];
      logic [SET_W-1:0]  pair_left[$];
      logic [SET_W-1:0]  pair_right[$];
      logic [EDGE_W-1:0] pair_edge[$];
      bit                exhausted;
      int unsigned       pair_quota = 1024;
      int unsigned       node_span  = 0;
      outcome_type       owed_outcomes[$];
      int                errors;
      int                checked;
      int                stops;
      int                completes;

      function bit set_known(logic [SET_W-1:0] s);
         foreach (seen_sets[i])
            if (seen_sets[i] == s) return 1;
         return 0;
      endfunction

      function bit add_set(logic [SET_W-1:0] s);
         if (set_known(s) || seen_sets.size() >= MAX_SEEN_DEF) return 0;
         seen_sets = {seen_sets, s};
         return 1;
      endfunction

      function bit pair_known(logic [SET_W-1:0] a, logic [SET_W-1:0] b);
         foreach (pair_left[i])
            if ((pair_left[i] == a && pair_right[i] == b) ||
                (pair_left[i] == b && pair_right[i] == a)) return 1;
         return 0;
      endfunction

      function void write_reg(reg_idx_type idx, logic [CSR_DW-1:0] value);
         if (idx == REG_PAIR_QUOTA) pair_quota = value[BUDGET_W-1:0];
         else node_span = value[NCOUNT_W-1:0];
      endfunction

      function void record_event(op_type op, logic [NODE_W-1:0] node,
                                 logic [SET_W-1:0] a, logic [SET_W-1:0] b,
                                 logic [EDGE_W-1:0] edge_id);
         outcome_type o;
         int unsigned cap;
         logic [SET_W-1:0] full;
         o = '0;
         if (op == OP_SINGLE) begin
            o.set_added = add_set(SET_W'(1) << node);
         end else if (!pair_known(a, b)) begin
            cap = (pair_quota > MAX_PAIRS_DEF) ? MAX_PAIRS_DEF : pair_quota;
            if (pair_left.size() >= cap) begin
               exhausted = 1;
               o.stop = 1;
            end else begin
               pair_left  = {pair_left, a};
               pair_right = {pair_right, b};
               pair_edge  = {pair_edge, edge_id};
               o.pair_added = 1;
               o.set_added = add_set(a | b);
            end
         end
         // The full set of the first node-span nodes; 64 nodes is all ones.
         full = (node_span >= 64) ? '1 : ((SET_W'(1) << node_span) - 1);
         o.complete = !exhausted && node_span != 0 && node_span <= MAX_NODES_DEF
                      && set_known(full);
         owed_outcomes = {owed_outcomes, o};
      endfunction

      function void check_response(outcome_type got);
         outcome_type want;
         if (owed_outcomes.size() == 0) begin
            $display("%0t: response word with nothing owed: got %b", $time, got);
            errors++;
            return;
         end
         want = owed_outcomes.pop_front();
         checked++;
         stops += got.stop;
         completes += got.complete;
         if (got.stop !== want.stop)
            $display("%0t: stop expected %b actual %b", $time, want.stop, got.stop);
         if (got.pair_added !== want.pair_added)
            $display("%0t: pair_added expected %b actual %b", $time,
                     want.pair_added, got.pair_added);
         if (got.set_added !== want.set_added)
            $display("%0t: set_added expected %b actual %b", $time,
                     want.set_added, got.set_added);
         if (got.complete !== want.complete)
            $display("%0t: complete expected %b actual %b", $time,
                     want.complete, got.complete);
         if (got !== want) errors++;
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   sdt_req_if req_chan ();
   sdt_rsp_if rsp_chan ();

   subset_pair_dedup_table u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   dedup_scoreboard  board = new();
   logic [SET_W-1:0] set_pool[20];
   bit               calm;       // when set, neither side idles
   bit               hold_rsp;   // asks the receiver for one long hold-off
   int               words_sent;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // A gap of random length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // The receiver idles at random. A requested hold-off is counted here, in
   // cycles, while the sender keeps offering words so the block backs up.
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   // Every accepted response word is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_response('{rsp_chan.stop, rsp_chan.pair_added,
                                rsp_chan.set_added, rsp_chan.complete});
   end

   // Two-phase APB write; the register takes the value at the access edge.
   task automatic write_csr(reg_idx_type idx, logic [CSR_DW-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(4 * int'(idx));
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      board.write_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Offers one request word and returns once the block has taken it. The
   // valid is only dropped when a gap is wanted, so back-to-back words keep
   // it high without a second assignment in the same step.
   task automatic send_word(op_type op, logic [NODE_W-1:0] node,
                            logic [SET_W-1:0] a, logic [SET_W-1:0] b,
                            logic [EDGE_W-1:0] edge_id);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.node_id   <= node;
      req_chan.left_set  <= a;
      req_chan.right_set <= b;
      req_chan.edge_id   <= edge_id;
      do @(posedge clock); while (!req_chan.ready);
      board.record_event(op, node, a, b, edge_id);
      words_sent++;
   endtask

   // Lets the block drain: every owed response has come and the last event
   // has fully retired before a register is touched.
   task automatic wait_idle();
      @(posedge clock);
      req_chan.valid <= 1'b0;
      while (board.owed_outcomes.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   function automatic logic [SET_W-1:0] random_set();
      return {$urandom(), $urandom()};
   endfunction

   // Random traffic. Most pair words reuse sets from the pool, so duplicate
   // pairs and repeated unions come up often; a few use fresh sets.
   task automatic random_words(int count, bit with_pressure);
      logic [SET_W-1:0] a, b;
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0) calm = ($urandom_range(3) == 0);
         if (with_pressure && n == 100) hold_rsp = 1;
         if (with_pressure && n == 200) begin
            // The sender withdraws its word and pauses until everything owed
            // has come back.
            req_chan.valid <= 1'b0;
            while (board.owed_outcomes.size() != 0) @(posedge clock);
         end
         if ($urandom_range(99) < 25) begin
            send_word(OP_SINGLE, NODE_W'($urandom_range(63)), random_set(),
                      random_set(), EDGE_W'($urandom()));
         end else begin
            a = ($urandom_range(9) == 0) ? random_set() : set_pool[$urandom_range(19)];
            b = ($urandom_range(9) == 0) ? random_set() : set_pool[$urandom_range(19)];
            send_word(OP_PAIR, NODE_W'($urandom()), a, b, EDGE_W'($urandom()));
         end
      end
      calm = 0;
   endtask

   initial begin
      reset          <= 1'b1;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      req_chan.valid <= 1'b0;
      req_chan.operation <= OP_SINGLE;
      req_chan.node_id   <= '0;
      req_chan.left_set  <= '0;
      req_chan.right_set <= '0;
      req_chan.edge_id   <= '0;
      foreach (set_pool[i]) set_pool[i] = random_set();
      set_pool[0] = '0;
      set_pool[1] = '1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // A budget above the pair store saturates; one node makes complete easy.
      write_csr(REG_PAIR_QUOTA, 2047);
      write_csr(REG_NODE_SPAN, 1);
      send_word(OP_SINGLE, 0, '0, '0, '0);
      send_word(OP_SINGLE, 0, '1, '1, '1);          // repeated singleton
      send_word(OP_SINGLE, 63, '0, '0, '0);
      send_word(OP_PAIR, 0, 64'h3, 64'hC, 16'hFFFF);
      send_word(OP_PAIR, 0, 64'hC, 64'h3, 16'h0);   // same pair, swapped
      send_word(OP_PAIR, 0, '0, '0, '0);
      send_word(OP_PAIR, 63, '1, '0, 16'h1234);
      send_word(OP_PAIR, 0, 64'h8000_0000_0000_0001, 64'h1, 16'h8000);
      send_word(OP_PAIR, 0, 64'h1, 64'h8000_0000_0000_0001, 16'h7FFF);
      wait_idle();
      // Walk the node span through its interesting values.
      write_csr(REG_NODE_SPAN, 4);
      send_word(OP_SINGLE, 5, '0, '0, '0);
      wait_idle();
      write_csr(REG_NODE_SPAN, 64);
      send_word(OP_SINGLE, 6, '0, '0, '0);
      wait_idle();
      write_csr(REG_NODE_SPAN, 127);
      send_word(OP_SINGLE, 7, '0, '0, '0);
      wait_idle();
      write_csr(REG_NODE_SPAN, 0);
      send_word(OP_SINGLE, 8, '0, '0, '0);
      wait_idle();
      write_csr(REG_NODE_SPAN, 4);
      random_words(420, 1);
      wait_idle();

      // Budget below the stored pairs: a new pair stops and sets the flag.
      write_csr(REG_PAIR_QUOTA, 1);
      send_word(OP_PAIR, 0, random_set(), random_set(), 16'hABCD);
      send_word(OP_SINGLE, 9, '0, '0, '0);
      wait_idle();
      write_csr(REG_PAIR_QUOTA, 0);
      send_word(OP_PAIR, 0, random_set(), random_set(), 16'h0001);
      wait_idle();
      // Raising the budget lets pairs in again, but complete stays low.
      write_csr(REG_PAIR_QUOTA, 1024);
      write_csr(REG_NODE_SPAN, 2);
      random_words(490, 0);
      wait_idle();
      repeat (50) @(posedge clock);

      $display("Ran %0d request words, checked %0d responses (%0d stops, %0d complete).",
               words_sent, board.checked, board.stops, board.completes);
      $display("Stores ended with %0d pairs and %0d seen sets.",
               board.pair_left.size(), board.seen_sets.size());
      if (board.errors == 0 && board.owed_outcomes.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #200ms;
      $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire
